// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while reset is released.
`define LCHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LCHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lchs_pkg.sv
package lchs_pkg;

  localparam int MEDIA_W      = 3;
  localparam int CFG_ADDR_W   = 1;
  localparam int SPT_W        = 6;
  localparam int CYLS_W       = 7;
  localparam int CYL_W        = 13;
  localparam int SEC_W        = 6;
  localparam int START_W      = 16;
  localparam int DIV_W        = 4;
  localparam int REM_W        = 5;
  localparam int RESID_W      = 4;
  localparam int RECIP_W      = 32;
  localparam int RECIP_SHIFT  = 35;
  localparam int PIPE_STAGES  = 6;

  localparam int OUT_TDATA_W   = 48;
  localparam int OUT_PAD_W     = OUT_TDATA_W - (CYL_W + 1 + SEC_W + 1 + START_W + SPT_W);
  localparam int OUT_HEAD_BIT  = CYL_W;
  localparam int OUT_SEC_LSB   = OUT_HEAD_BIT + 1;
  localparam int OUT_RANGE_BIT = OUT_SEC_LSB + SEC_W;
  localparam int OUT_START_LSB = OUT_RANGE_BIT + 1;
  localparam int OUT_LEN_LSB   = OUT_START_LSB + START_W;

  typedef logic [MEDIA_W-1:0]    media_code_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  typedef enum logic [MEDIA_W-1:0] {
    MEDIA_NONE  = 3'd0,
    MEDIA_360K  = 3'd1,
    MEDIA_1M2   = 3'd2,
    MEDIA_720K  = 3'd3,
    MEDIA_1M44  = 3'd4,
    MEDIA_2M88  = 3'd5,
    MEDIA_RSVD6 = 3'd6,
    MEDIA_RSVD7 = 3'd7
  } media_t;

  localparam cfg_addr_t CFG_DRIVE0_MEDIA = 1'b0;
  localparam cfg_addr_t CFG_DRIVE1_MEDIA = 1'b1;

  localparam logic [RECIP_W-1:0] RECIP_9  = 32'd3817748707;
  localparam logic [RECIP_W-1:0] RECIP_15 = 32'd2290649224;
  localparam logic [DIV_W-1:0]   DIV_9    = 4'd9;
  localparam logic [DIV_W-1:0]   DIV_15   = 4'd15;

  // Sectors per track is 9 or 15 times a power of two; the division runs on
  // the base divisor after a right shift of the sector address.
  typedef struct packed {
    logic              good;
    logic              div15;
    logic [1:0]        pre_shift;
    logic [SPT_W-1:0]  spt;
    logic [CYLS_W-1:0] cyls;
  } geo_t;

  function automatic geo_t geo_lookup(input media_code_t code);
    geo_t g;
    g = '0;
    case (code)
      MEDIA_360K: begin
        g.good = 1'b1; g.spt = 6'd9;  g.cyls = 7'd40;
      end
      MEDIA_1M2: begin
        g.good = 1'b1; g.div15 = 1'b1; g.spt = 6'd15; g.cyls = 7'd80;
      end
      MEDIA_720K: begin
        g.good = 1'b1; g.spt = 6'd9;  g.cyls = 7'd80;
      end
      MEDIA_1M44: begin
        g.good = 1'b1; g.pre_shift = 2'd1; g.spt = 6'd18; g.cyls = 7'd80;
      end
      MEDIA_2M88: begin
        g.good = 1'b1; g.pre_shift = 2'd2; g.spt = 6'd36; g.cyls = 7'd80;
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [DIV_W-1:0] geo_divisor(input geo_t g);
    return g.div15 ? DIV_15 : DIV_9;
  endfunction

  function automatic logic [RECIP_W-1:0] geo_recip(input geo_t g);
    return g.div15 ? RECIP_15 : RECIP_9;
  endfunction

endpackage

// File: hdl/lchs_decode.sv
module lchs_decode #(
  parameter int AW = 16
) (
  input  logic                          clk,
  input  logic                          ld,
  input  lchs_pkg::media_code_t         code,
  input  logic [AW-1:0]                 abs_sector,
  output logic [AW-1:0]                 xs_r,
  output logic [lchs_pkg::START_W-1:0]  x16_r,
  output lchs_pkg::geo_t                geo_r
);
  import lchs_pkg::*;

  geo_t          geo_nxt;
  logic [AW-1:0] xs_nxt;

  always_comb begin
    geo_nxt = geo_lookup(code);
    xs_nxt  = abs_sector >> geo_nxt.pre_shift;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      geo_r <= geo_nxt;
      xs_r  <= xs_nxt;
      x16_r <= START_W'(abs_sector);
    end
  end

endmodule

// File: hdl/lchs_divider.sv
module lchs_divider #(
  parameter int AW = 16
) (
  input  logic                          clk,
  input  logic [3:0]                    ld,
  input  logic [AW-1:0]                 xs,
  input  logic [lchs_pkg::START_W-1:0]  x16,
  input  lchs_pkg::geo_t                geo,
  output logic [AW-1:0]                 q_r,
  output logic [lchs_pkg::SEC_W-1:0]    sec0_r,
  output logic [lchs_pkg::START_W-1:0]  x16_r,
  output lchs_pkg::geo_t                geo_r
);
  import lchs_pkg::*;

  localparam int PW = AW + RECIP_W;

  // Stage 1: product with the reciprocal of the base divisor.
  logic [PW-1:0]      prod1_r;
  logic [AW-1:0]      xs1_r;
  logic [START_W-1:0] x16_1_r;
  geo_t               geo1_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod1_r <= PW'(xs) * PW'(geo_recip(geo));
      xs1_r   <= xs;
      x16_1_r <= x16;
      geo1_r  <= geo;
    end
  end

  // Stage 2: quotient estimate, low by at most one.
  logic [AW-1:0]      qe2_r;
  logic [AW-1:0]      xs2_r;
  logic [START_W-1:0] x16_2_r;
  geo_t               geo2_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      qe2_r   <= AW'(prod1_r >> RECIP_SHIFT);
      xs2_r   <= xs1_r;
      x16_2_r <= x16_1_r;
      geo2_r  <= geo1_r;
    end
  end

  // Stage 3: partial remainder, below twice the divisor.
  logic [AW+DIV_W-1:0] qd3;
  logic [AW-1:0]       diff3;
  logic [REM_W-1:0]    rem3_r;
  logic [AW-1:0]       qe3_r;
  logic [START_W-1:0]  x16_3_r;
  geo_t                geo3_r;

  always_comb begin
    qd3   = (AW+DIV_W)'(qe2_r) * (AW+DIV_W)'(geo_divisor(geo2_r));
    diff3 = xs2_r - qd3[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      rem3_r  <= diff3[REM_W-1:0];
      qe3_r   <= qe2_r;
      x16_3_r <= x16_2_r;
      geo3_r  <= geo2_r;
    end
  end

  // Stage 4: one correction step, then the shifted-out bits rejoin the remainder.
  logic [REM_W-1:0]   div4;
  logic               fix4;
  logic [RESID_W-1:0] resid4;
  logic [SEC_W-1:0]   sec0_nxt;

  always_comb begin
    div4   = {1'b0, geo_divisor(geo3_r)};
    fix4   = (rem3_r >= div4);
    resid4 = fix4 ? RESID_W'(rem3_r - div4) : rem3_r[RESID_W-1:0];
    case (geo3_r.pre_shift)
      2'd0:    sec0_nxt = {2'b00, resid4};
      2'd1:    sec0_nxt = {1'b0, resid4, x16_3_r[0]};
      default: sec0_nxt = {resid4, x16_3_r[1:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      q_r    <= qe3_r + AW'(fix4);
      sec0_r <= sec0_nxt;
      x16_r  <= x16_3_r;
      geo_r  <= geo3_r;
    end
  end

endmodule

// File: hdl/lchs_format.sv
module lchs_format #(
  parameter int AW = 16
) (
  input  logic                             clk,
  input  logic                             ld,
  input  logic [AW-1:0]                    q,
  input  logic [lchs_pkg::SEC_W-1:0]       sec0,
  input  logic [lchs_pkg::START_W-1:0]     x16,
  input  lchs_pkg::geo_t                   geo,
  output logic [lchs_pkg::OUT_TDATA_W-1:0] tdata_r
);
  import lchs_pkg::*;

  logic [AW-2:0]          cyl_full;
  logic                   in_range;
  logic [SEC_W-1:0]       sector;
  logic [START_W-1:0]     start;
  logic [OUT_TDATA_W-1:0] tdata_nxt;

  always_comb begin
    cyl_full = q[AW-1:1];
    in_range = geo.good && (cyl_full < (AW-1)'(geo.cyls));
    sector   = sec0 + 6'd1;
    start    = x16 - START_W'(sec0);
    if (geo.good) begin
      tdata_nxt = {{OUT_PAD_W{1'b0}}, geo.spt, start, in_range, sector, q[0],
                   CYL_W'(cyl_full)};
    end else begin
      tdata_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      tdata_r <= tdata_nxt;
    end
  end

endmodule

// File: hdl/lba_to_chs_geometry_core.sv
// Each accepted word passes the six stages in order: decode, reciprocal multiply,
// quotient estimate, remainder, correction and output register (out_tvalid).
// Throughput: one word per cycle unless the output stalls.
// A stalled output fills the bubbles upstream before in_tready drops.
// Reset: synchronous active-low rst_n empties the pipeline and sets both
// drive media types to none.
module lba_to_chs_geometry_core #(
  parameter int DRIVE_COUNT       = 2,
  parameter int SECTOR_ADDR_WIDTH = 16,
  localparam int IN_TDATA_W       = ((SECTOR_ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  lchs_pkg::cfg_addr_t              cfg_addr,
  input  logic [lchs_pkg::MEDIA_W-1:0]     cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_TDATA_W-1:0]            in_tdata,   // abs_sector
  input  logic                             in_tuser,   // drive_select
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cylinder_number, head_number, sector_number, in_range, track_start, track_length
  output logic [lchs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lchs_pkg::*;

  localparam int AW = SECTOR_ADDR_WIDTH;

  media_code_t media0_r;
  media_code_t code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media0_r <= MEDIA_NONE;
    end else if (cfg_we && cfg_addr == CFG_DRIVE0_MEDIA) begin
      media0_r <= cfg_wdata;
    end
  end

  generate
    if (DRIVE_COUNT > 1) begin : g_two_drives
      media_code_t media1_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          media1_r <= MEDIA_NONE;
        end else if (cfg_we && cfg_addr == CFG_DRIVE1_MEDIA) begin
          media1_r <= cfg_wdata;
        end
      end

      assign code = in_tuser ? media1_r : media0_r;
    end else begin : g_one_drive
      assign code = in_tuser ? MEDIA_NONE : media0_r;
    end
  endgenerate

  // Each stage loads when it is empty or when the stage after it loads.
  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;
  logic [PIPE_STAGES-1:0] ld;

  always_comb begin
    ld[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || out_tready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ld[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (ld[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[PIPE_STAGES-1];

  logic [AW-1:0]      dec_xs;
  logic [START_W-1:0] dec_x16;
  geo_t               dec_geo;

  lchs_decode #(.AW(AW)) u_decode (
    .clk        (clk),
    .ld         (ld[0]),
    .code       (code),
    .abs_sector (in_tdata[AW-1:0]),
    .xs_r       (dec_xs),
    .x16_r      (dec_x16),
    .geo_r      (dec_geo)
  );

  logic [AW-1:0]      div_q;
  logic [SEC_W-1:0]   div_sec0;
  logic [START_W-1:0] div_x16;
  geo_t               div_geo;

  lchs_divider #(.AW(AW)) u_divider (
    .clk    (clk),
    .ld     (ld[4:1]),
    .xs     (dec_xs),
    .x16    (dec_x16),
    .geo    (dec_geo),
    .q_r    (div_q),
    .sec0_r (div_sec0),
    .x16_r  (div_x16),
    .geo_r  (div_geo)
  );

  lchs_format #(.AW(AW)) u_format (
    .clk     (clk),
    .ld      (ld[5]),
    .q       (div_q),
    .sec0    (div_sec0),
    .x16     (div_x16),
    .geo     (div_geo),
    .tdata_r (out_tdata)
  );

endmodule

// File: hdl/lchs_checker.sv
`include "assert_macros.svh"

module lchs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lchs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lchs_pkg::*;

  logic [SEC_W-1:0] sec;
  logic [SPT_W-1:0] len;
  logic             stall;
  logic             no_geo;
  logic             has_geo;

  assign sec     = out_tdata[OUT_SEC_LSB +: SEC_W];
  assign len     = out_tdata[OUT_LEN_LSB +: SPT_W];
  assign stall   = out_tvalid && !out_tready;
  assign no_geo  = out_tvalid && (sec == '0);
  assign has_geo = out_tvalid && (len != '0);

  `LCHS_ASSERT(a_out_hold, stall |=> out_tvalid && $stable(out_tdata), "held word changed")
  `LCHS_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled while output empty")
  `LCHS_ASSERT(a_no_geometry_zero, no_geo |-> out_tdata == '0, "word without geometry not zero")
  `LCHS_ASSERT(a_sector_in_track, has_geo |-> sec != '0 && sec <= len, "sector outside its track")
  `LCHS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind lba_to_chs_geometry_core lchs_checker u_lchs_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lchs_pkg::*;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS   = 140;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [CYL_W-1:0]   cylinder;
    logic               head;
    logic [SEC_W-1:0]   sector;
    logic               in_range;
    logic [START_W-1:0] track_start;
    logic [SPT_W-1:0]   track_length;
  } chs_t;

  class chs_scoreboard;
    localparam int HEADS = 2;
    media_code_t media[2];
    chs_t        pending_chs[$];
    int unsigned requests;
    int unsigned words;
    int unsigned mismatches;

    static function void media_geometry(input media_code_t code,
                                        output int unsigned spt, output int unsigned cyls);
      case (code)
        MEDIA_360K: begin
          spt = 9;  cyls = 40;
        end
        MEDIA_1M2: begin
          spt = 15; cyls = 80;
        end
        MEDIA_720K: begin
          spt = 9;  cyls = 80;
        end
        MEDIA_1M44: begin
          spt = 18; cyls = 80;
        end
        MEDIA_2M88: begin
          spt = 36; cyls = 80;
        end
        default: begin
          spt = 0;  cyls = 0;
        end
      endcase
    endfunction

    function chs_t translate(input media_code_t code, input logic [START_W-1:0] lba);
      int unsigned spt, cyls, trk, offset;
      chs_t r;
      r = '0;
      media_geometry(code, spt, cyls);
      if (spt != 0) begin
        offset         = lba % spt;
        trk            = lba / spt;
        r.cylinder     = CYL_W'(trk / HEADS);
        r.head         = 1'(trk % HEADS);
        r.sector       = SEC_W'(offset + 1);
        r.in_range     = (trk / HEADS) < cyls;
        r.track_start  = START_W'(lba - offset);
        r.track_length = SPT_W'(spt);
      end
      return r;
    endfunction

    function void set_media(input cfg_addr_t idx, input media_code_t code);
      media[idx] = code;
    endfunction

    function void note_request(input logic drive, input logic [START_W-1:0] lba);
      pending_chs.push_back(translate(media[drive], lba));
      requests++;
    endfunction

    function void check_word(input logic [OUT_TDATA_W-1:0] w);
      chs_t got, want;
      got.cylinder     = w[CYL_W-1:0];
      got.head         = w[OUT_HEAD_BIT];
      got.sector       = w[OUT_SEC_LSB +: SEC_W];
      got.in_range     = w[OUT_RANGE_BIT];
      got.track_start  = w[OUT_START_LSB +: START_W];
      got.track_length = w[OUT_LEN_LSB +: SPT_W];
      words++;
      if (pending_chs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output word %h with no request pending", w);
        return;
      end
      want = pending_chs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on word %0d:", words);
          $display("  expected cyl %0d head %0d sec %0d in_range %0d start %0d len %0d",
                   want.cylinder, want.head, want.sector, want.in_range,
                   want.track_start, want.track_length);
          $display("  got      cyl %0d head %0d sec %0d in_range %0d start %0d len %0d",
                   got.cylinder, got.head, got.sector, got.in_range,
                   got.track_start, got.track_length);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  cfg_addr_t              cfg_addr;
  logic [MEDIA_W-1:0]     cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [START_W-1:0]     in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   quiet;
  logic                   want_hold;
  int unsigned            cycle_count = 0;
  int unsigned            settings = 0;
  chs_scoreboard          sb = new;

  lba_to_chs_geometry_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_request(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The long hold-off is counted here so the sender keeps offering words meanwhile.
  initial begin
    int  hold_left;
    bit  held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && want_hold) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  task automatic set_drives(input media_code_t c0, input media_code_t c1);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DRIVE0_MEDIA;
    cfg_wdata <= c0;
    @(posedge clk);
    cfg_addr  <= CFG_DRIVE1_MEDIA;
    cfg_wdata <= c1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_media(CFG_DRIVE0_MEDIA, c0);
    sb.set_media(CFG_DRIVE1_MEDIA, c1);
    settings++;
  endtask

  task automatic send_request(input logic drive, input logic [START_W-1:0] lba);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= drive;
    in_tdata  <= lba;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_chs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Most sectors fall on the media, some straddle its end, the rest span the whole field.
  function automatic logic [START_W-1:0] pick_sector(input media_code_t code);
    int unsigned spt, cyls, lim, mode;
    chs_scoreboard::media_geometry(code, spt, cyls);
    lim  = spt * cyls * 2;
    mode = $urandom_range(0, 9);
    if (lim == 0 || mode >= 8) return START_W'($urandom_range(0, 65535));
    if (mode >= 6) return START_W'($urandom_range(lim - 40, lim + 40));
    return START_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic run_directed(input media_code_t c0, input media_code_t c1);
    media_code_t code;
    int unsigned spt, cyls, lim;
    set_drives(c0, c1);
    for (int d = 0; d < 2; d++) begin
      code = d ? c1 : c0;
      chs_scoreboard::media_geometry(code, spt, cyls);
      lim = spt * cyls * 2;
      send_request(d[0], '0);
      if (lim != 0) begin
        send_request(d[0], START_W'(lim - 1));
        send_request(d[0], START_W'(lim));
      end
      send_request(d[0], '1);
    end
    drain();
  endtask

  task automatic run_phase(input media_code_t c0, input media_code_t c1, input int unsigned n);
    logic drive;
    set_drives(c0, c1);
    repeat (n) begin
      drive = 1'($urandom_range(0, 1));
      send_request(drive, pick_sector(drive ? c1 : c0));
    end
    drain();
  endtask

  initial begin
    media_code_t c0, c1;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_DRIVE0_MEDIA;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    quiet     = 1'b0;
    want_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed(MEDIA_360K, MEDIA_1M2);
    run_directed(MEDIA_720K, MEDIA_1M44);
    run_directed(MEDIA_2M88, MEDIA_NONE);
    run_directed(MEDIA_RSVD6, MEDIA_RSVD7);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c0 = MEDIA_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(0, 7));
      c1 = MEDIA_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(0, 7));
      quiet <= (p == 3);
      if (p == 6) begin
        want_hold <= 1'b1;
      end
      run_phase(c0, c1, PHASE_WORDS);
    end

    $display("Translated %0d sector requests under %0d drive media settings,",
             sb.requests, settings);
    $display("covering every media code, media end boundaries and a long output stall.");
    if (sb.mismatches == 0 && sb.pending_chs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
